[hw/rtl/pavt_pkg.sv]
// types, constants and microprogram of the pose anchor vertex transform
`default_nettype none
package pavt_pkg;

	localparam int NUM_VERTS = 4;
	localparam int DATA_W = 32;
	localparam int CFG_W = 20;
	localparam int ACC_W = 36;
	localparam int SLOT_W = 3;
	localparam int VIDX_W = $clog2(NUM_VERTS);
	localparam int PC_W = 4;

	localparam logic CFG_AXIS_LENGTH = 1'b0;
	localparam logic CFG_ANCHOR_DIST = 1'b1;
	localparam logic [CFG_W-1:0] AXIS_LENGTH_RST = 20'd13107;
	localparam logic [CFG_W-1:0] ANCHOR_DIST_RST = 20'd32768;

	localparam logic [2:0] SRC_MEM = 3'd0;
	localparam logic [2:0] SRC_DEVQ = 3'd1;
	localparam logic [2:0] SRC_DEVT = 3'd2;
	localparam logic [2:0] SRC_ANCP = 3'd3;
	localparam logic [2:0] SRC_VERTP = 3'd4;

	localparam logic [1:0] MOD_NONE = 2'd0;
	localparam logic [1:0] MOD_CONJ = 2'd1;
	localparam logic [1:0] MOD_CONJ2 = 2'd2;
	localparam logic [1:0] MOD_ZW = 2'd3;

	localparam logic [1:0] OP_QMUL = 2'd0;
	localparam logic [1:0] OP_VADD = 2'd1;
	localparam logic [1:0] OP_COPY = 2'd2;

	localparam logic [SLOT_W-1:0] SL_T1 = 3'd0;
	localparam logic [SLOT_W-1:0] SL_T2 = 3'd1;
	localparam logic [SLOT_W-1:0] SL_T3 = 3'd2;
	localparam logic [SLOT_W-1:0] SL_AT = 3'd3;
	localparam logic [SLOT_W-1:0] SL_AR = 3'd4;
	localparam logic [SLOT_W-1:0] SL_RR = 3'd5;
	localparam logic [SLOT_W-1:0] SL_REL = 3'd6;

	localparam logic [PC_W-1:0] PC_ANC = 4'd0;
	localparam logic [PC_W-1:0] PC_MAIN = 4'd4;
	localparam logic [PC_W-1:0] PC_VERT = 4'd10;
	localparam logic [PC_W-1:0] PC_LAST = 4'd12;

	typedef struct packed {
		logic [2:0] src;
		logic [SLOT_W-1:0] slot;
		logic [1:0] mode;
	} opnd_t;

	typedef struct packed {
		logic [1:0] kind;
		opnd_t a;
		opnd_t b;
		logic dst_out;
		logic [SLOT_W-1:0] dst;
	} op_t;

	typedef struct packed {
		logic valid;
		logic pass;
		logic neg;
		logic first;
		logic last;
		opnd_t a;
		logic [1:0] a_comp;
		opnd_t b;
		logic [1:0] b_comp;
		logic dst_out;
		logic [SLOT_W-1:0] dst_slot;
		logic [1:0] dst_comp;
		logic [VIDX_W-1:0] vk;
	} term_t;

	typedef struct packed {
		logic capture;
		logic emit;
		logic [VIDX_W-1:0] index;
		logic last;
		term_t term;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} stat_t;

	typedef struct packed {
		logic [1:0] a_comp;
		logic [1:0] b_comp;
		logic neg;
	} qterm_t;

	function automatic opnd_t od(input logic [2:0] src, input logic [SLOT_W-1:0] slot,
		input logic [1:0] mode);
		opnd_t r;
		r.src = src;
		r.slot = slot;
		r.mode = mode;
		return r;
	endfunction

	function automatic op_t mk_op(input logic [1:0] kind, input opnd_t a, input opnd_t b,
		input logic dst_out, input logic [SLOT_W-1:0] dst);
		op_t r;
		r.kind = kind;
		r.a = a;
		r.b = b;
		r.dst_out = dst_out;
		r.dst = dst;
		return r;
	endfunction

	// quaternion product terms, components x y z w
	function automatic qterm_t qterm(input logic [1:0] c, input logic [1:0] j);
		qterm_t r;
		unique case ({c, j})
			4'h0: r = '{2'd0, 2'd3, 1'b0};
			4'h1: r = '{2'd3, 2'd0, 1'b0};
			4'h2: r = '{2'd2, 2'd1, 1'b1};
			4'h3: r = '{2'd1, 2'd2, 1'b0};
			4'h4: r = '{2'd1, 2'd3, 1'b0};
			4'h5: r = '{2'd2, 2'd0, 1'b0};
			4'h6: r = '{2'd3, 2'd1, 1'b0};
			4'h7: r = '{2'd0, 2'd2, 1'b1};
			4'h8: r = '{2'd2, 2'd3, 1'b0};
			4'h9: r = '{2'd1, 2'd0, 1'b1};
			4'ha: r = '{2'd0, 2'd1, 1'b0};
			4'hb: r = '{2'd3, 2'd2, 1'b0};
			4'hc: r = '{2'd3, 2'd3, 1'b0};
			4'hd: r = '{2'd0, 2'd0, 1'b1};
			4'he: r = '{2'd1, 2'd1, 1'b1};
			default: r = '{2'd2, 2'd2, 1'b1};
		endcase
		return r;
	endfunction

	function automatic op_t prog_op(input logic [PC_W-1:0] pc);
		op_t r;
		unique case (pc)
			// anchor placement
			4'd0: r = mk_op(OP_QMUL, od(SRC_DEVQ, SL_T1, MOD_NONE),
				od(SRC_ANCP, SL_T1, MOD_NONE), 1'b0, SL_T1);
			4'd1: r = mk_op(OP_QMUL, od(SRC_MEM, SL_T1, MOD_NONE),
				od(SRC_DEVQ, SL_T1, MOD_CONJ), 1'b0, SL_T2);
			4'd2: r = mk_op(OP_VADD, od(SRC_MEM, SL_T2, MOD_NONE),
				od(SRC_DEVT, SL_T1, MOD_NONE), 1'b0, SL_AT);
			4'd3: r = mk_op(OP_COPY, od(SRC_DEVQ, SL_T1, MOD_NONE),
				od(SRC_DEVQ, SL_T1, MOD_NONE), 1'b0, SL_AR);
			// relative pose
			4'd4: r = mk_op(OP_QMUL, od(SRC_DEVQ, SL_T1, MOD_CONJ),
				od(SRC_DEVT, SL_T1, MOD_NONE), 1'b0, SL_T1);
			4'd5: r = mk_op(OP_QMUL, od(SRC_MEM, SL_T1, MOD_NONE),
				od(SRC_DEVQ, SL_T1, MOD_CONJ2), 1'b0, SL_T2);
			4'd6: r = mk_op(OP_QMUL, od(SRC_DEVQ, SL_T1, MOD_CONJ),
				od(SRC_MEM, SL_AR, MOD_NONE), 1'b0, SL_RR);
			4'd7: r = mk_op(OP_QMUL, od(SRC_DEVQ, SL_T1, MOD_CONJ),
				od(SRC_MEM, SL_AT, MOD_ZW), 1'b0, SL_T1);
			4'd8: r = mk_op(OP_QMUL, od(SRC_MEM, SL_T1, MOD_NONE),
				od(SRC_DEVQ, SL_T1, MOD_CONJ2), 1'b0, SL_T3);
			4'd9: r = mk_op(OP_VADD, od(SRC_MEM, SL_T3, MOD_NONE),
				od(SRC_MEM, SL_T2, MOD_CONJ), 1'b0, SL_REL);
			// per vertex
			4'd10: r = mk_op(OP_QMUL, od(SRC_MEM, SL_RR, MOD_NONE),
				od(SRC_VERTP, SL_T1, MOD_NONE), 1'b0, SL_T1);
			4'd11: r = mk_op(OP_QMUL, od(SRC_MEM, SL_T1, MOD_NONE),
				od(SRC_MEM, SL_RR, MOD_CONJ), 1'b0, SL_T2);
			4'd12: r = mk_op(OP_VADD, od(SRC_MEM, SL_T2, MOD_NONE),
				od(SRC_MEM, SL_REL, MOD_NONE), 1'b1, SL_T1);
			default: r = mk_op(OP_COPY, od(SRC_DEVQ, SL_T1, MOD_NONE),
				od(SRC_DEVQ, SL_T1, MOD_NONE), 1'b0, SL_T1);
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/pavt_pose_if.sv]
// pose input channel
`default_nettype none
interface pavt_pose_if;
	logic valid;
	logic ready;
	logic signed [31:0] dev_tx;
	logic signed [31:0] dev_ty;
	logic signed [31:0] dev_tz;
	logic signed [31:0] dev_qx;
	logic signed [31:0] dev_qy;
	logic signed [31:0] dev_qz;
	logic signed [31:0] dev_qw;
	logic reset_anchor;

	modport source (output valid, dev_tx, dev_ty, dev_tz, dev_qx, dev_qy, dev_qz, dev_qw,
		reset_anchor, input ready);
	modport sink (input valid, dev_tx, dev_ty, dev_tz, dev_qx, dev_qy, dev_qz, dev_qw,
		reset_anchor, output ready);
endinterface
`default_nettype wire

[hw/rtl/pavt_vert_if.sv]
// vertex output channel
`default_nettype none
interface pavt_vert_if;
	logic valid;
	logic ready;
	logic signed [31:0] vert_x;
	logic signed [31:0] vert_y;
	logic signed [31:0] vert_z;
	logic [1:0] vert_index;
	logic last_vert;

	modport source (output valid, vert_x, vert_y, vert_z, vert_index, last_vert,
		input ready);
	modport sink (input valid, vert_x, vert_y, vert_z, vert_index, last_vert,
		output ready);
endinterface
`default_nettype wire

[hw/rtl/pavt_ctrl.sv]
// sequencer stepping the microprogram one multiply term per cycle unless a busy output stalls it
`default_nettype none
module pavt_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_reset_anchor,
	output logic in_ready,
	input pavt_pkg::stat_t stat,
	output pavt_pkg::cmd_t cmd
);
	import pavt_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] DRAIN_LAST = 2'd2;

	logic [1:0] state_q;
	logic [PC_W-1:0] pc_q;
	logic [1:0] c_q;
	logic [1:0] j_q;
	logic [1:0] dcnt_q;
	logic [VIDX_W-1:0] k_q;
	logic anchored_q;

	op_t op;
	qterm_t qt;
	logic [1:0] last_c;
	logic [1:0] last_j;
	logic stall;
	logic op_done;
	logic last_vk;

	always_comb begin
		op = prog_op(pc_q);
		qt = qterm(c_q, j_q);
		last_c = (op.kind == OP_VADD) ? 2'd2 : 2'd3;
		unique case (op.kind)
			OP_QMUL: last_j = 2'd3;
			OP_VADD: last_j = 2'd1;
			default: last_j = 2'd0;
		endcase
		stall = op.dst_out & stat.out_busy;
		op_done = (state_q == ST_DRAIN) && (dcnt_q == DRAIN_LAST);
		last_vk = (k_q == VIDX_W'(NUM_VERTS - 1));
		in_ready = (state_q == ST_IDLE);

		cmd = '0;
		cmd.capture = in_valid & in_ready;
		cmd.emit = op_done & op.dst_out;
		cmd.index = k_q;
		cmd.last = last_vk;
		cmd.term.valid = (state_q == ST_ISSUE) & ~stall;
		cmd.term.first = (j_q == 2'd0);
		cmd.term.last = (j_q == last_j);
		cmd.term.dst_out = op.dst_out;
		cmd.term.dst_slot = op.dst;
		cmd.term.dst_comp = c_q;
		cmd.term.vk = k_q;
		cmd.term.b = op.b;
		cmd.term.b_comp = c_q;
		if (op.kind == OP_QMUL) begin
			cmd.term.pass = 1'b0;
			cmd.term.neg = qt.neg;
			cmd.term.a = op.a;
			cmd.term.a_comp = qt.a_comp;
			cmd.term.b_comp = qt.b_comp;
		end else begin
			cmd.term.pass = 1'b1;
			cmd.term.neg = 1'b0;
			cmd.term.a = (j_q == 2'd1) ? op.b : op.a;
			cmd.term.a_comp = c_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= PC_ANC;
			c_q <= 2'd0;
			j_q <= 2'd0;
			dcnt_q <= 2'd0;
			k_q <= '0;
			anchored_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						pc_q <= (!anchored_q || in_reset_anchor) ? PC_ANC : PC_MAIN;
						anchored_q <= 1'b1;
						k_q <= '0;
						c_q <= 2'd0;
						j_q <= 2'd0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (!stall) begin
						if (j_q == last_j) begin
							j_q <= 2'd0;
							if (c_q == last_c) begin
								dcnt_q <= 2'd0;
								state_q <= ST_DRAIN;
							end else begin
								c_q <= c_q + 2'd1;
							end
						end else begin
							j_q <= j_q + 2'd1;
						end
					end
				end
				ST_DRAIN: begin
					if (op_done) begin
						c_q <= 2'd0;
						state_q <= ST_ISSUE;
						if (pc_q == PC_LAST) begin
							if (last_vk) begin
								state_q <= ST_IDLE;
							end else begin
								k_q <= k_q + VIDX_W'(1);
								pc_q <= PC_VERT;
							end
						end else begin
							pc_q <= pc_q + PC_W'(1);
						end
					end else begin
						dcnt_q <= dcnt_q + 2'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[hw/rtl/pavt_datapath.sv]
// operand store, shared multiplier, accumulator and output register
`default_nettype none
module pavt_datapath (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [pavt_pkg::CFG_W-1:0] cfg_wdata,
	input pavt_pkg::cmd_t cmd,
	output pavt_pkg::stat_t stat,
	input wire logic signed [31:0] dev_tx,
	input wire logic signed [31:0] dev_ty,
	input wire logic signed [31:0] dev_tz,
	input wire logic signed [31:0] dev_qx,
	input wire logic signed [31:0] dev_qy,
	input wire logic signed [31:0] dev_qz,
	input wire logic signed [31:0] dev_qw,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [31:0] vert_x,
	output logic signed [31:0] vert_y,
	output logic signed [31:0] vert_z,
	output logic [pavt_pkg::VIDX_W-1:0] vert_index,
	output logic last_vert
);
	import pavt_pkg::*;

	localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7fffffff;
	localparam logic signed [DATA_W-1:0] S_MIN = 32'sh80000000;
	localparam logic signed [ACC_W-1:0] ACC_MAX = 36'sd2147483647;
	localparam logic signed [ACC_W-1:0] ACC_MIN = -36'sd2147483648;
	localparam logic signed [63:0] RND_HALF = 64'sd536870912;

	logic [CFG_W-1:0] axis_length_q;
	logic [CFG_W-1:0] anchor_dist_q;
	logic signed [DATA_W-1:0] devq_q [4];
	logic signed [DATA_W-1:0] devt_q [3];
	logic [DATA_W-1:0] rf_q [32];
	logic [DATA_W-1:0] rd_a_s1;
	logic [DATA_W-1:0] rd_b_s1;
	term_t ctl_s1;
	term_t ctl_s2;
	logic signed [63:0] prod_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [DATA_W-1:0] vout_q [3];
	logic [VIDX_W-1:0] vidx_q;
	logic vlast_q;
	logic ovalid_q;

	logic signed [DATA_W-1:0] a_val;
	logic signed [DATA_W-1:0] b_val;
	logic signed [63:0] prod;
	logic signed [63:0] rnd;
	logic signed [ACC_W-1:0] term_x;
	logic signed [ACC_W-1:0] acc_base;
	logic signed [ACC_W-1:0] sum;
	logic signed [DATA_W-1:0] sum_sat;

	function automatic logic signed [DATA_W-1:0] satneg(input logic signed [DATA_W-1:0] x);
		return (x == S_MIN) ? S_MAX : -x;
	endfunction

	function automatic logic signed [DATA_W-1:0] operand(input opnd_t o,
		input logic [1:0] comp, input logic [DATA_W-1:0] mem,
		input logic signed [DATA_W-1:0] q, input logic signed [DATA_W-1:0] t,
		input logic [CFG_W-1:0] ad, input logic [CFG_W-1:0] al,
		input logic [VIDX_W-1:0] vk);
		logic signed [DATA_W-1:0] raw;
		logic signed [DATA_W-1:0] r;
		unique case (o.src)
			SRC_MEM: raw = mem;
			SRC_DEVQ: raw = q;
			SRC_DEVT: raw = (comp == 2'd3) ? '0 : t;
			SRC_ANCP: raw = (comp == 2'd2) ? -$signed({12'd0, ad}) : '0;
			SRC_VERTP: raw = (vk != '0 && comp == 2'(vk - VIDX_W'(1))) ?
				$signed({12'd0, al}) : '0;
			default: raw = '0;
		endcase
		r = raw;
		if (comp != 2'd3) begin
			if (o.mode == MOD_CONJ) r = satneg(raw);
			else if (o.mode == MOD_CONJ2) r = satneg(satneg(raw));
		end else if (o.mode == MOD_ZW) begin
			r = '0;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_length_q <= AXIS_LENGTH_RST;
			anchor_dist_q <= ANCHOR_DIST_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_AXIS_LENGTH: axis_length_q <= cfg_wdata;
				CFG_ANCHOR_DIST: anchor_dist_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			devq_q[0] <= dev_qx;
			devq_q[1] <= dev_qy;
			devq_q[2] <= dev_qz;
			devq_q[3] <= dev_qw;
			devt_q[0] <= dev_tx;
			devt_q[1] <= dev_ty;
			devt_q[2] <= dev_tz;
		end
	end

	// operand store
	always_ff @(posedge clk) begin
		rd_a_s1 <= rf_q[{cmd.term.a.slot, cmd.term.a_comp}];
		rd_b_s1 <= rf_q[{cmd.term.b.slot, cmd.term.b_comp}];
	end

	always_ff @(posedge clk) begin
		if (ctl_s2.valid && ctl_s2.last && !ctl_s2.dst_out) begin
			rf_q[{ctl_s2.dst_slot, ctl_s2.dst_comp}] <= sum_sat;
		end
	end

	always_comb begin
		a_val = operand(ctl_s1.a, ctl_s1.a_comp, rd_a_s1, devq_q[ctl_s1.a_comp],
			devt_q[2'(ctl_s1.a_comp == 2'd3 ? 2'd0 : ctl_s1.a_comp)],
			anchor_dist_q, axis_length_q, ctl_s1.vk);
		b_val = operand(ctl_s1.b, ctl_s1.b_comp, rd_b_s1, devq_q[ctl_s1.b_comp],
			devt_q[2'(ctl_s1.b_comp == 2'd3 ? 2'd0 : ctl_s1.b_comp)],
			anchor_dist_q, axis_length_q, ctl_s1.vk);
		if (ctl_s1.pass) prod = {{2{a_val[31]}}, a_val, 30'd0};
		else prod = a_val * b_val;
	end

	always_comb begin
		rnd = prod_s2 + RND_HALF;
		term_x = {{2{rnd[63]}}, rnd[63:30]};
		acc_base = ctl_s2.first ? '0 : acc_q;
		sum = ctl_s2.neg ? (acc_base - term_x) : (acc_base + term_x);
		if (sum > ACC_MAX) sum_sat = S_MAX;
		else if (sum < ACC_MIN) sum_sat = S_MIN;
		else sum_sat = sum[DATA_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= cmd.term;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= prod;
		if (ctl_s2.valid) acc_q <= sum;
		if (ctl_s2.valid && ctl_s2.last && ctl_s2.dst_out) begin
			vout_q[ctl_s2.dst_comp] <= sum_sat;
		end
		if (cmd.emit) begin
			vidx_q <= cmd.index;
			vlast_q <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.emit) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	assign stat.out_busy = ovalid_q;
	assign out_valid = ovalid_q;
	assign vert_x = vout_q[0];
	assign vert_y = vout_q[1];
	assign vert_z = vout_q[2];
	assign vert_index = vidx_q;
	assign last_vert = vlast_q;
endmodule
`default_nettype wire

[hw/rtl/pose_anchor_vertex_transform_unit.sv]
// top level of the pose anchor vertex transform
//
// channel   dir  payload                                           transaction
// pose      in   dev_tx/ty/tz, dev_qx/qy/qz/qw, reset_anchor        valid & ready
// vert      out  vert_x/y/z, vert_index, last_vert                  valid & ready
// cfg       in   cfg_index 0 axis_length, 1 anchor_distance         cfg_we
//
// one shared 32x32 multiplier takes one product term per cycle unless the vert
// channel stalls the output operation; each operation then drains the pipeline.
// one pose is worked on at a time; pose ready is high only while idle. arst_n
// clears the sequencer, the anchor flag, the output valid and the cfg registers
// to their reset values.
`default_nettype none
module pose_anchor_vertex_transform_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [pavt_pkg::CFG_W-1:0] cfg_wdata,
	pavt_pose_if.sink pose,
	pavt_vert_if.source vert
);
	import pavt_pkg::*;

	cmd_t cmd;
	stat_t stat;

	pavt_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(pose.valid),
		.in_reset_anchor(pose.reset_anchor),
		.in_ready(pose.ready),
		.stat(stat),
		.cmd(cmd)
	);

	pavt_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cmd(cmd),
		.stat(stat),
		.dev_tx(pose.dev_tx),
		.dev_ty(pose.dev_ty),
		.dev_tz(pose.dev_tz),
		.dev_qx(pose.dev_qx),
		.dev_qy(pose.dev_qy),
		.dev_qz(pose.dev_qz),
		.dev_qw(pose.dev_qw),
		.out_valid(vert.valid),
		.out_ready(vert.ready),
		.vert_x(vert.vert_x),
		.vert_y(vert.vert_y),
		.vert_z(vert.vert_z),
		.vert_index(vert.vert_index),
		.last_vert(vert.last_vert)
	);
endmodule
`default_nettype wire

[tb/sv/pose_anchor_vertex_checker.sv]
// checker: predicts the four vertices of each pose and compares the vert channel
module pose_anchor_vertex_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [pavt_pkg::CFG_W-1:0] cfg_wdata,
	pavt_pose_if pose,
	pavt_vert_if vert,
	output int errors,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import pavt_pkg::*;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [1:0] index;
		logic last;
	} vertex_t;

	vertex_t vertex_q[$];
	logic [CFG_W-1:0] arm_len;
	logic [CFG_W-1:0] anchor_dist;
	bit anchored;
	longint anchor_t[3];
	longint anchor_q[4];

	function automatic longint clip(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint mul_q30(input longint a, input longint b);
		longint p;
		p = a * b + (64'sd1 <<< 29);
		return p >>> 30;
	endfunction

	function automatic void quat_mul(input longint a[4], input longint b[4], output longint r[4]);
		r[0] = clip(mul_q30(a[0], b[3]) + mul_q30(a[3], b[0]) - mul_q30(a[2], b[1])
			+ mul_q30(a[1], b[2]));
		r[1] = clip(mul_q30(a[1], b[3]) + mul_q30(a[2], b[0]) + mul_q30(a[3], b[1])
			- mul_q30(a[0], b[2]));
		r[2] = clip(mul_q30(a[2], b[3]) - mul_q30(a[1], b[0]) + mul_q30(a[0], b[1])
			+ mul_q30(a[3], b[2]));
		r[3] = clip(mul_q30(a[3], b[3]) - mul_q30(a[0], b[0]) - mul_q30(a[1], b[1])
			- mul_q30(a[2], b[2]));
	endfunction

	function automatic void quat_conj(input longint q[4], output longint r[4]);
		r[0] = clip(-q[0]);
		r[1] = clip(-q[1]);
		r[2] = clip(-q[2]);
		r[3] = q[3];
	endfunction

	function automatic void rotate_vec(input longint q[4], input longint v[3], output longint r[3]);
		longint vq[4];
		longint t[4];
		longint qc[4];
		longint u[4];
		vq[0] = v[0];
		vq[1] = v[1];
		vq[2] = v[2];
		vq[3] = 0;
		quat_mul(q, vq, t);
		quat_conj(q, qc);
		quat_mul(t, qc, u);
		r[0] = u[0];
		r[1] = u[1];
		r[2] = u[2];
	endfunction

	task automatic predict_pose();
		longint t[3];
		longint q[4];
		longint qc[4];
		longint tmp[3];
		longint rt[3];
		longint rr[4];
		longint rel[3];
		longint p[3];
		longint v[3];
		vertex_t e;
		t[0] = pose.dev_tx;
		t[1] = pose.dev_ty;
		t[2] = pose.dev_tz;
		q[0] = pose.dev_qx;
		q[1] = pose.dev_qy;
		q[2] = pose.dev_qz;
		q[3] = pose.dev_qw;
		if (!anchored || pose.reset_anchor) begin
			p[0] = 0;
			p[1] = 0;
			p[2] = -longint'(anchor_dist);
			rotate_vec(q, p, tmp);
			for (int i = 0; i < 3; i++) anchor_t[i] = clip(tmp[i] + t[i]);
			anchor_q = q;
			anchored = 1;
		end
		quat_conj(q, qc);
		rotate_vec(qc, t, tmp);
		for (int i = 0; i < 3; i++) tmp[i] = clip(-tmp[i]);
		quat_mul(qc, anchor_q, rr);
		rotate_vec(qc, anchor_t, rt);
		for (int i = 0; i < 3; i++) rel[i] = clip(rt[i] + tmp[i]);
		for (int k = 0; k < NUM_VERTS; k++) begin
			p[0] = 0;
			p[1] = 0;
			p[2] = 0;
			if (k >= 1) p[k-1] = longint'(arm_len);
			rotate_vec(rr, p, v);
			e.x = 32'(clip(v[0] + rel[0]));
			e.y = 32'(clip(v[1] + rel[1]));
			e.z = 32'(clip(v[2] + rel[2]));
			e.index = 2'(k);
			e.last = (k == NUM_VERTS - 1);
			vertex_q.push_back(e);
		end
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_len = AXIS_LENGTH_RST;
			anchor_dist = ANCHOR_DIST_RST;
			anchored = 0;
			vertex_q.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_AXIS_LENGTH) arm_len = cfg_wdata;
				else anchor_dist = cfg_wdata;
			end
			if (pose.valid && pose.ready) predict_pose();
			if (vert.valid && vert.ready) begin
				vertex_t e;
				if (vertex_q.size() == 0) begin
					report("unexpected vertex", vert.vert_x, 0);
				end else begin
					e = vertex_q.pop_front();
					if (vert.vert_x !== e.x) report("vert_x", vert.vert_x, e.x);
					if (vert.vert_y !== e.y) report("vert_y", vert.vert_y, e.y);
					if (vert.vert_z !== e.z) report("vert_z", vert.vert_z, e.z);
					if (vert.vert_index !== e.index) report("vert_index", vert.vert_index, e.index);
					if (vert.last_vert !== e.last) report("last_vert", vert.last_vert, e.last);
				end
			end
		end
		pending = vertex_q.size();
	end

	initial begin
		errors = 0;
		pending = 0;
	end
endmodule

[tb/sv/tb_pose_anchor_vertex_transform_unit.sv]
// testbench top: pose stimulus, register settings and verdict
module tb_pose_anchor_vertex_transform_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import pavt_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam logic signed [31:0] S_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] S_MIN = 32'sh80000000;
	localparam logic signed [31:0] Q_ONE = 32'sh40000000;
	localparam logic signed [31:0] Q_HALF_SQRT2 = 32'sd759250125;

	typedef struct {
		logic signed [31:0] tx, ty, tz, qx, qy, qz, qw;
		logic ra;
	} pose_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [CFG_W-1:0] cfg_wdata;
	int errors;
	int pending;
	int cycles;
	int hold_cnt;
	bit hold_req;
	bit calm;

	pavt_pose_if pose();
	pavt_vert_if vert();

	pose_anchor_vertex_transform_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.pose(pose),
		.vert(vert)
	);

	pose_anchor_vertex_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.pose(pose),
		.vert(vert),
		.errors(errors),
		.pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("pose_anchor_vertex_transform_unit test failed");
			$finish;
		end
	end

	// sink side stalls, with one long hold-off on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 0;
			hold_cnt = 1500;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			vert.ready <= 1'b0;
		end else begin
			vert.ready <= calm || ($urandom_range(99) >= 12);
		end
	end

	function automatic pose_t mk(input logic signed [31:0] tx, ty, tz, qx, qy, qz, qw,
		input logic ra);
		pose_t p;
		p.tx = tx;
		p.ty = ty;
		p.tz = tz;
		p.qx = qx;
		p.qy = qy;
		p.qz = qz;
		p.qw = qw;
		p.ra = ra;
		return p;
	endfunction

	function automatic logic signed [31:0] corner();
		case ($urandom_range(3))
			0: return S_MAX;
			1: return S_MIN;
			2: return 0;
			default: return Q_ONE;
		endcase
	endfunction

	function automatic pose_t rand_pose();
		pose_t p;
		int kind;
		kind = $urandom_range(99);
		if (kind < 70) begin
			p.tx = $signed($urandom) >>> $urandom_range(8, 20);
			p.ty = $signed($urandom) >>> $urandom_range(8, 20);
			p.tz = $signed($urandom) >>> $urandom_range(8, 20);
			p.qx = $signed($urandom) >>> $urandom_range(2, 4);
			p.qy = $signed($urandom) >>> $urandom_range(2, 4);
			p.qz = $signed($urandom) >>> $urandom_range(2, 4);
			p.qw = $signed($urandom) >>> 2;
		end else if (kind < 90) begin
			p.tx = $urandom;
			p.ty = $urandom;
			p.tz = $urandom;
			p.qx = $urandom;
			p.qy = $urandom;
			p.qz = $urandom;
			p.qw = $urandom;
		end else begin
			p.tx = corner();
			p.ty = corner();
			p.tz = corner();
			p.qx = corner();
			p.qy = corner();
			p.qz = corner();
			p.qw = corner();
		end
		p.ra = ($urandom_range(99) < 15);
		return p;
	endfunction

	task automatic push(input pose_t p);
		pose.dev_tx <= p.tx;
		pose.dev_ty <= p.ty;
		pose.dev_tz <= p.tz;
		pose.dev_qx <= p.qx;
		pose.dev_qy <= p.qy;
		pose.dev_qz <= p.qz;
		pose.dev_qw <= p.qw;
		pose.reset_anchor <= p.ra;
		pose.valid <= 1'b1;
		do @(posedge clk); while (!pose.ready);
		if (!calm && $urandom_range(99) < 12) begin
			pose.valid <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	endtask

	task automatic settle();
		pose.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_regs(input logic [CFG_W-1:0] arm, input logic [CFG_W-1:0] reach);
		cfg_we <= 1'b1;
		cfg_index <= CFG_AXIS_LENGTH;
		cfg_wdata <= arm;
		@(posedge clk);
		cfg_index <= CFG_ANCHOR_DIST;
		cfg_wdata <= reach;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		pose_t dir_q[$];
		cycles = 0;
		hold_cnt = 0;
		hold_req = 0;
		calm = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = CFG_AXIS_LENGTH;
		cfg_wdata = '0;
		pose.valid = 0;
		pose.dev_tx = 0;
		pose.dev_ty = 0;
		pose.dev_tz = 0;
		pose.dev_qx = 0;
		pose.dev_qy = 0;
		pose.dev_qz = 0;
		pose.dev_qw = 0;
		pose.reset_anchor = 0;
		vert.ready = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first pose places the anchor even without reset_anchor
		dir_q.push_back(mk(0, 0, 0, 0, 0, 0, Q_ONE, 0));
		dir_q.push_back(mk(65536, -65536, 131072, 0, 0, 0, Q_ONE, 0));
		dir_q.push_back(mk(0, 0, 0, 0, Q_HALF_SQRT2, 0, Q_HALF_SQRT2, 0));
		dir_q.push_back(mk(0, 0, 0, 0, Q_HALF_SQRT2, 0, Q_HALF_SQRT2, 1));
		dir_q.push_back(mk(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 1));
		dir_q.push_back(mk(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, 0));
		dir_q.push_back(mk(100, -100, 7, S_MIN, S_MIN, S_MIN, S_MIN, 1));
		dir_q.push_back(mk(65536, 65536, 65536, 0, 0, 0, 0, 0));
		dir_q.push_back(mk(S_MAX, S_MIN, S_MAX, 0, 0, 0, Q_ONE, 1));
		dir_q.push_back(mk(-65536, 0, 65536, 0, 0, 0, S_MAX, 1));
		dir_q.push_back(mk(0, 0, 0, Q_HALF_SQRT2, 0, 0, Q_HALF_SQRT2, 0));
		dir_q.push_back(mk(12345, 54321, -999, 0, 0, Q_HALF_SQRT2, -Q_ONE, 1));
		foreach (dir_q[i]) push(dir_q[i]);

		settle();
		write_regs(0, 0);
		repeat (80) push(rand_pose());

		settle();
		write_regs(20'd655360, 20'd655360);
		hold_req = 1;
		repeat (85) push(rand_pose());

		settle();
		write_regs(20'hfffff, 20'hfffff);
		calm = 1;
		repeat (85) push(rand_pose());
		calm = 0;

		settle();
		write_regs(20'd1, 20'd655360);
		repeat (80) push(rand_pose());

		settle();
		write_regs(20'($urandom_range(0, 655360)), 20'($urandom_range(0, 655360)));
		repeat (85) push(rand_pose());

		settle();
		if (errors == 0 && pending == 0) begin
			$display("pose_anchor_vertex_transform_unit test passed");
		end else begin
			$display("pose_anchor_vertex_transform_unit test failed");
		end
		$finish;
	end
endmodule
